// File: hw/rtl/wds_pkg.sv
// Shared types, constants and helpers for the weighed dosing sequencer.
// No dependencies; every other file in hw/rtl imports this package.
package wds_pkg;

    localparam int NUM_BOTTLES = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int BOTTLE_W    = $clog2(NUM_BOTTLES);
    localparam int POS_W       = BOTTLE_W + 1;
    localparam int SPEED_W     = 7;
    localparam int DRIVE_W     = SPEED_W + 1;
    localparam int PUMP_W      = 8;
    localparam int CODE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // All ones reads as -1, the selector position is not known.
    localparam logic signed [POS_W-1:0] POS_UNKNOWN = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_GLASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_LEVEL  = 2'd2;

    localparam logic [15:0]        RST_EMPTY_GLASS = 16'd200;
    localparam logic [SPEED_W-1:0] RST_SEL_SPEED   = 7'd25;
    localparam logic [PUMP_W-1:0]  RST_PUMP_LEVEL  = 8'd40;

    localparam logic [CODE_W-1:0] CODE_INACTIVE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_REFERENCE = 3'd1;
    localparam logic [CODE_W-1:0] CODE_IDLE      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SEEK      = 3'd3;
    localparam logic [CODE_W-1:0] CODE_PUMP      = 3'd4;
    localparam logic [CODE_W-1:0] CODE_FILLED    = 3'd5;

    typedef enum logic [5:0] {
        PH_INACTIVE  = 6'b000001,
        PH_REFERENCE = 6'b000010,
        PH_IDLE      = 6'b000100,
        PH_SEEK      = 6'b001000,
        PH_PUMP      = 6'b010000,
        PH_FILLED    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [15:0]        empty_glass_weight;
        logic [SPEED_W-1:0] selector_speed;
        logic [PUMP_W-1:0]  pump_level;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] selector_index;
        logic [WEIGHT_BITS-1:0]  glass_weight;
        logic                    stop_mode;
        logic                    error_flag;
        logic                    critical_flag;
        logic                    step_present;
        logic [BOTTLE_W-1:0]     step_bottle;
        logic [WEIGHT_BITS-1:0]  step_amount;
        logic                    step_final;
    } t_item;

    typedef struct packed {
        t_phase                    phase;
        logic [BOTTLE_W-1:0]       target_bottle;
        logic [WEIGHT_BITS-1:0]    target_amount;
        logic                      target_final;
        logic [WEIGHT_BITS-1:0]    base_weight;
        logic signed [DRIVE_W-1:0] selector_cmd;
    } t_state;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] selector_drive;
        logic [PUMP_W-1:0]         pump_drive;
        logic                      module_done;
        logic                      pop_step;
        logic [CODE_W-1:0]         phase_code;
    } t_result;

    function automatic logic [CODE_W-1:0] phase_to_code(input t_phase ph);
        logic [CODE_W-1:0] code;
        unique case (ph)
            PH_INACTIVE:  code = CODE_INACTIVE;
            PH_REFERENCE: code = CODE_REFERENCE;
            PH_IDLE:      code = CODE_IDLE;
            PH_SEEK:      code = CODE_SEEK;
            PH_PUMP:      code = CODE_PUMP;
            PH_FILLED:    code = CODE_FILLED;
            default:      code = CODE_INACTIVE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/wds_cfg.sv
// Configuration register file of the weighed dosing sequencer.
// Depends on wds_pkg for the register indexes, reset values and t_cfg.
module wds_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [wds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output wds_pkg::t_cfg                   o_cfg
);
    import wds_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.empty_glass_weight <= RST_EMPTY_GLASS;
            r_cfg.selector_speed     <= RST_SEL_SPEED;
            r_cfg.pump_level         <= RST_PUMP_LEVEL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_EMPTY_GLASS: r_cfg.empty_glass_weight <= i_cfg_data;
                CFG_SEL_SPEED:   r_cfg.selector_speed     <= i_cfg_data[SPEED_W-1:0];
                CFG_PUMP_LEVEL:  r_cfg.pump_level         <= i_cfg_data[PUMP_W-1:0];
                default: begin
                    // Writes to indexes beyond the register list are dropped.
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/wds_step.sv
// Phase decision logic: one sensor tick against the current state.
// Depends on wds_pkg for the item, state, result and configuration types.
module wds_step (
    input  wds_pkg::t_cfg    i_cfg,
    input  wds_pkg::t_state  i_state,
    input  wds_pkg::t_item   i_item,
    output wds_pkg::t_state  o_state,
    output wds_pkg::t_result o_result
);
    import wds_pkg::*;

    logic                      flagged;
    t_phase                    cur_phase;
    t_state                    nxt;
    logic signed [DRIVE_W-1:0] spd_pos;
    logic signed [DRIVE_W-1:0] spd_neg;
    logic signed [POS_W-1:0]   tgt_pos;
    logic                      pos_unknown;
    logic [WEIGHT_BITS:0]      fill_goal;
    logic [PUMP_W-1:0]         pump;
    logic                      done;
    logic                      pop;

    assign flagged     = i_item.stop_mode | i_item.error_flag | i_item.critical_flag;
    assign cur_phase   = flagged ? PH_INACTIVE : i_state.phase;
    assign spd_pos     = $signed({1'b0, i_cfg.selector_speed});
    assign spd_neg     = -spd_pos;
    assign tgt_pos     = $signed({1'b0, i_state.target_bottle});
    assign pos_unknown = (i_item.selector_index == POS_UNKNOWN);
    // One bit wider than the weights so the target never wraps.
    assign fill_goal   = {1'b0, i_state.target_amount} + {1'b0, i_state.base_weight};

    always_comb begin
        nxt       = i_state;
        nxt.phase = cur_phase;
        pump      = '0;
        done      = 1'b0;
        pop       = 1'b0;
        unique case (cur_phase)
            PH_INACTIVE: begin
                nxt.selector_cmd = '0;
                if (!flagged) begin
                    nxt.phase = PH_REFERENCE;
                end
            end
            PH_REFERENCE: begin
                if (pos_unknown) begin
                    nxt.selector_cmd = spd_neg;
                end else begin
                    nxt.selector_cmd = '0;
                    nxt.phase        = PH_IDLE;
                end
            end
            PH_IDLE: begin
                done             = 1'b1;
                nxt.selector_cmd = '0;
                if (i_item.step_present) begin
                    nxt.target_bottle = i_item.step_bottle;
                    nxt.target_amount = i_item.step_amount;
                    nxt.target_final  = i_item.step_final;
                    if ((i_item.step_amount != '0) &&
                        (i_item.glass_weight > i_cfg.empty_glass_weight)) begin
                        nxt.base_weight = i_item.glass_weight;
                        nxt.phase       = PH_SEEK;
                    end
                end
            end
            PH_SEEK: begin
                if (pos_unknown) begin
                    // Keep an ongoing positive sweep, otherwise back off negative.
                    if (i_state.selector_cmd != spd_pos) begin
                        nxt.selector_cmd = spd_neg;
                    end
                end else if (i_item.selector_index < tgt_pos) begin
                    nxt.selector_cmd = spd_pos;
                end else if (i_item.selector_index > tgt_pos) begin
                    nxt.selector_cmd = spd_neg;
                end else begin
                    nxt.selector_cmd = '0;
                    nxt.base_weight  = i_item.glass_weight;
                    nxt.phase        = PH_PUMP;
                end
            end
            PH_PUMP: begin
                if ({1'b0, i_item.glass_weight} < fill_goal) begin
                    pump = i_cfg.pump_level;
                end else begin
                    pop       = 1'b1;
                    nxt.phase = i_state.target_final ? PH_FILLED : PH_IDLE;
                end
            end
            PH_FILLED: begin
                done = 1'b1;
                if (i_item.glass_weight < i_cfg.empty_glass_weight) begin
                    nxt.phase = PH_IDLE;
                end
            end
            default: begin
                nxt.selector_cmd = '0;
            end
        endcase
    end

    assign o_state                 = nxt;
    assign o_result.selector_drive = nxt.selector_cmd;
    assign o_result.pump_drive     = pump;
    assign o_result.module_done    = done;
    assign o_result.pop_step       = pop;
    assign o_result.phase_code     = phase_to_code(nxt.phase);

endmodule

// File: hw/rtl/weighed_dosing_sequencer.sv
// Top level of the weighed dosing sequencer: input register, state, result register.
// Depends on wds_pkg, wds_cfg and wds_step.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_selector_index .. i_step_final
//   result    out        o_valid / i_stall    o_selector_drive .. o_phase_code
//   config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// A request is first captured in the input register; the phase decision and the
// state update happen as it moves into the result register, and one request is
// taken every cycle while the result side flows.
// Reset is synchronous and active low; it puts the phase to reference.
// A stall on the result side holds the result register, and the input register
// then stalls the request side once it is full.
module weighed_dosing_sequencer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [wds_pkg::POS_W-1:0]       i_selector_index,
    input  logic [wds_pkg::WEIGHT_BITS-1:0]        i_glass_weight,
    input  logic                                   i_stop_mode,
    input  logic                                   i_error_flag,
    input  logic                                   i_critical_flag,
    input  logic                                   i_step_present,
    input  logic [wds_pkg::BOTTLE_W-1:0]           i_step_bottle,
    input  logic [wds_pkg::WEIGHT_BITS-1:0]        i_step_amount,
    input  logic                                   i_step_final,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [wds_pkg::DRIVE_W-1:0]     o_selector_drive,
    output logic [wds_pkg::PUMP_W-1:0]             o_pump_drive,
    output logic                                   o_module_done,
    output logic                                   o_pop_step,
    output logic [wds_pkg::CODE_W-1:0]             o_phase_code,
    input  logic                                   i_cfg_wr_en,
    input  logic [wds_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import wds_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    advance;
    logic    take_in;

    assign advance = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & ~advance;
    assign take_in = i_valid & ~o_stall;

    wds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wds_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= take_in | (r_in_valid & ~advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.selector_index <= i_selector_index;
            r_in.glass_weight   <= i_glass_weight;
            r_in.stop_mode      <= i_stop_mode;
            r_in.error_flag     <= i_error_flag;
            r_in.critical_flag  <= i_critical_flag;
            r_in.step_present   <= i_step_present;
            r_in.step_bottle    <= i_step_bottle;
            r_in.step_amount    <= i_step_amount;
            r_in.step_final     <= i_step_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_REFERENCE;
            r_state.target_bottle <= '0;
            r_state.target_amount <= '0;
            r_state.target_final  <= 1'b0;
            r_state.base_weight   <= '0;
            r_state.selector_cmd  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance | (r_out_valid & i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_selector_drive = r_out.selector_drive;
    assign o_pump_drive     = r_out.pump_drive;
    assign o_module_done    = r_out.module_done;
    assign o_pop_step       = r_out.pop_step;
    assign o_phase_code     = r_out.phase_code;

    // The pump only runs in the pump phase.
    a_pump_only_in_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pump_drive != '0)) |-> (o_phase_code == CODE_PUMP))
        else $error("pump driven outside the pump phase");

    // A finished dose never reports the pump as running or the module as done.
    a_pop_stops_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pop_step) |-> (o_pump_drive == '0 && !o_module_done))
        else $error("pop issued with pump running or module done");

    // Entering the inactive phase always zeroes the selector.
    a_inactive_stops_selector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_phase_code == CODE_INACTIVE)) |-> (o_selector_drive == '0))
        else $error("selector driven in inactive phase");

    // The committed state only moves when a result is produced.
    a_state_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a result");

endmodule

// File: verif/weighed_dosing_sequencer_test.sv
// Self-checking testbench for weighed_dosing_sequencer: directed and random sensor ticks,
// register changes between phases, random gaps and stalls on both channels.
// Depends on wds_pkg and the RTL of weighed_dosing_sequencer only.
module weighed_dosing_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wds_pkg::*;

    localparam int UNKNOWN_POS = -1;
    localparam logic [2:0] FLAG_NONE     = 3'b000;
    localparam logic [2:0] FLAG_STOP     = 3'b100;
    localparam logic [2:0] FLAG_ERROR    = 3'b010;
    localparam logic [2:0] FLAG_CRITICAL = 3'b001;
    localparam logic [2:0] FLAG_ALL      = 3'b111;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [POS_W-1:0]   i_selector_index;
    logic [WEIGHT_BITS-1:0]    i_glass_weight;
    logic                      i_stop_mode;
    logic                      i_error_flag;
    logic                      i_critical_flag;
    logic                      i_step_present;
    logic [BOTTLE_W-1:0]       i_step_bottle;
    logic [WEIGHT_BITS-1:0]    i_step_amount;
    logic                      i_step_final;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [DRIVE_W-1:0] o_selector_drive;
    logic [PUMP_W-1:0]         o_pump_drive;
    logic                      o_module_done;
    logic                      o_pop_step;
    logic [CODE_W-1:0]         o_phase_code;
    logic                      i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    weighed_dosing_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_selector_index (i_selector_index),
        .i_glass_weight   (i_glass_weight),
        .i_stop_mode      (i_stop_mode),
        .i_error_flag     (i_error_flag),
        .i_critical_flag  (i_critical_flag),
        .i_step_present   (i_step_present),
        .i_step_bottle    (i_step_bottle),
        .i_step_amount    (i_step_amount),
        .i_step_final     (i_step_final),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_selector_drive (o_selector_drive),
        .o_pump_drive     (o_pump_drive),
        .o_module_done    (o_module_done),
        .o_pop_step       (o_pop_step),
        .o_phase_code     (o_phase_code),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Sequencer state and register copies kept by the testbench.
    logic [CODE_W-1:0]      seq_phase;
    logic [BOTTLE_W-1:0]    seq_bottle;
    logic [WEIGHT_BITS-1:0] seq_amount;
    logic                   seq_final;
    logic [WEIGHT_BITS-1:0] seq_base;
    int                     seq_drive;
    logic [15:0]            cfg_empty;
    logic [SPEED_W-1:0]     cfg_speed;
    logic [PUMP_W-1:0]      cfg_pump;

    t_result awaited_commands[$];
    int      errors;
    int      burst_left;
    bit      gaps_on;
    bit      stall_on;
    int      stall_max;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 100)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    function automatic void reset_sequencer();
        seq_phase  = CODE_REFERENCE;
        seq_bottle = '0;
        seq_amount = '0;
        seq_final  = 1'b0;
        seq_base   = '0;
        seq_drive  = 0;
        cfg_empty  = RST_EMPTY_GLASS;
        cfg_speed  = RST_SEL_SPEED;
        cfg_pump   = RST_PUMP_LEVEL;
    endfunction

    // One sensor tick: flags first, then the decision of the current phase.
    function automatic t_result advance_sequencer(input t_item it);
        t_result    res;
        int         pos;
        int         spd;
        int         tb;
        logic       flagged;
        logic [7:0] pump;
        logic       done;
        logic       pop;
        pos     = int'($signed(it.selector_index));
        spd     = int'(cfg_speed);
        flagged = it.stop_mode | it.error_flag | it.critical_flag;
        pump    = '0;
        done    = 1'b0;
        pop     = 1'b0;
        if (flagged)
            seq_phase = CODE_INACTIVE;
        case (seq_phase)
            CODE_INACTIVE: begin
                seq_drive = 0;
                if (!flagged)
                    seq_phase = CODE_REFERENCE;
            end
            CODE_REFERENCE: begin
                if (pos == UNKNOWN_POS) begin
                    seq_drive = -spd;
                end else begin
                    seq_drive = 0;
                    seq_phase = CODE_IDLE;
                end
            end
            CODE_IDLE: begin
                done      = 1'b1;
                seq_drive = 0;
                if (it.step_present) begin
                    seq_bottle = it.step_bottle;
                    seq_amount = it.step_amount;
                    seq_final  = it.step_final;
                    if (seq_amount != 0 && it.glass_weight > cfg_empty) begin
                        seq_base  = it.glass_weight;
                        seq_phase = CODE_SEEK;
                    end
                end
            end
            CODE_SEEK: begin
                tb = int'(seq_bottle);
                if (pos != UNKNOWN_POS && pos < tb)
                    seq_drive = spd;
                if (pos != UNKNOWN_POS && pos > tb)
                    seq_drive = -spd;
                // Between positions a positive sweep is kept, anything else turns negative.
                if (pos == UNKNOWN_POS && seq_drive != spd)
                    seq_drive = -spd;
                if (pos == tb) begin
                    seq_drive = 0;
                    seq_base  = it.glass_weight;
                    seq_phase = CODE_PUMP;
                end
            end
            CODE_PUMP: begin
                // The target is summed as an int, wider than a weight, so it never wraps.
                if (int'(it.glass_weight) < int'(seq_amount) + int'(seq_base)) begin
                    pump = cfg_pump;
                end else begin
                    pop       = 1'b1;
                    seq_phase = seq_final ? CODE_FILLED : CODE_IDLE;
                end
            end
            CODE_FILLED: begin
                done = 1'b1;
                if (it.glass_weight < cfg_empty)
                    seq_phase = CODE_IDLE;
            end
            default: begin
                seq_drive = 0;
            end
        endcase
        res.selector_drive = seq_drive[7:0];
        res.pump_drive     = pump;
        res.module_done    = done;
        res.pop_step       = pop;
        res.phase_code     = seq_phase;
        return res;
    endfunction

    function automatic t_item make_request(input int pos, input int weight,
                                           input logic [2:0] flags, input logic present,
                                           input int bottle, input int amount,
                                           input logic fin);
        t_item it;
        it.selector_index = POS_W'(pos);
        it.glass_weight   = WEIGHT_BITS'(weight);
        it.stop_mode      = flags[2];
        it.error_flag     = flags[1];
        it.critical_flag  = flags[0];
        it.step_present   = present;
        it.step_bottle    = BOTTLE_W'(bottle);
        it.step_amount    = WEIGHT_BITS'(amount);
        it.step_final     = fin;
        return it;
    endfunction

    function automatic t_item noise_request();
        t_item it;
        it.selector_index = POS_W'(int'($urandom_range(0, 16)) - 1);
        it.glass_weight   = WEIGHT_BITS'($urandom());
        it.stop_mode      = 1'($urandom_range(0, 1));
        it.error_flag     = 1'($urandom_range(0, 1));
        it.critical_flag  = 1'($urandom_range(0, 1));
        it.step_present   = 1'($urandom_range(0, 1));
        it.step_bottle    = BOTTLE_W'($urandom());
        it.step_amount    = WEIGHT_BITS'($urandom());
        it.step_final     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // A tick that a real machine would plausibly produce in the current phase,
    // with rare faults so that most doses run through to the end.
    function automatic t_item shaped_request();
        t_item it;
        int    roll;
        int    thr;
        int    lim;
        it               = noise_request();
        it.stop_mode     = ($urandom_range(0, 99) == 0);
        it.error_flag    = ($urandom_range(0, 99) == 0);
        it.critical_flag = ($urandom_range(0, 99) == 0);
        it.step_present  = ($urandom_range(0, 9) != 0);
        roll = $urandom_range(0, 19);
        if (roll == 0)
            it.step_amount = '0;
        else if (roll == 1)
            it.step_amount = '1;
        else
            it.step_amount = WEIGHT_BITS'($urandom_range(1, 400));
        roll = $urandom_range(0, 9);
        case (seq_phase)
            CODE_REFERENCE: begin
                if (roll < 6)
                    it.selector_index = POS_W'(UNKNOWN_POS);
            end
            CODE_IDLE: begin
                if (roll < 6) begin
                    lim = int'(cfg_empty) + 3000;
                    if (lim > 65535)
                        lim = 65535;
                    if (cfg_empty == 16'hFFFF)
                        it.glass_weight = '1;
                    else
                        it.glass_weight = WEIGHT_BITS'($urandom_range(cfg_empty + 1, lim));
                end else begin
                    it.glass_weight = WEIGHT_BITS'($urandom_range(0, cfg_empty));
                end
            end
            CODE_SEEK: begin
                if (roll < 3)
                    it.selector_index = POS_W'(UNKNOWN_POS);
                else if (roll < 6)
                    it.selector_index = POS_W'(seq_bottle);
                it.glass_weight = WEIGHT_BITS'($urandom_range(0, 30000));
            end
            CODE_PUMP: begin
                thr = int'(seq_base) + int'(seq_amount);
                if (thr > 65535 || roll < 7) begin
                    lim = (thr - 1 > 65535) ? 65535 : thr - 1;
                    it.glass_weight = WEIGHT_BITS'($urandom_range(seq_base, lim));
                end else begin
                    lim = (thr + 40 > 65535) ? 65535 : thr + 40;
                    it.glass_weight = WEIGHT_BITS'($urandom_range(thr, lim));
                end
            end
            CODE_FILLED: begin
                if (roll < 7 || cfg_empty == 0)
                    it.glass_weight = WEIGHT_BITS'($urandom_range(cfg_empty, 65535));
                else
                    it.glass_weight = WEIGHT_BITS'($urandom_range(0, cfg_empty - 1));
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    task automatic send_request(input t_item it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 5);
            burst_left = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_selector_index <= it.selector_index;
        i_glass_weight   <= it.glass_weight;
        i_stop_mode      <= it.stop_mode;
        i_error_flag     <= it.error_flag;
        i_critical_flag  <= it.critical_flag;
        i_step_present   <= it.step_present;
        i_step_bottle    <= it.step_bottle;
        i_step_amount    <= it.step_amount;
        i_step_final     <= it.step_final;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        awaited_commands.push_back(advance_sequencer(it));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_commands.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while nothing is in flight, so the copy can follow at once.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_EMPTY_GLASS: cfg_empty = data;
            CFG_SEL_SPEED:   cfg_speed = data[SPEED_W-1:0];
            CFG_PUMP_LEVEL:  cfg_pump  = data[PUMP_W-1:0];
            default: begin
            end
        endcase
    endtask

    initial begin : stall_pattern
        int   run;
        logic hold;
        i_stall = 1'b0;
        run     = 0;
        hold    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                hold = ~hold;
                run  = hold ? $urandom_range(1, stall_max) : $urandom_range(1, 10);
            end
            run--;
            i_stall <= stall_on & hold;
        end
    end

    always @(posedge i_clk) begin : check_commands
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (awaited_commands.size() == 0) begin
                flag_mismatch("command with no request", int'(o_phase_code), 0);
            end else begin
                want = awaited_commands.pop_front();
                if (o_selector_drive !== want.selector_drive)
                    flag_mismatch("selector_drive", int'($signed(o_selector_drive)),
                                  int'($signed(want.selector_drive)));
                if (o_pump_drive !== want.pump_drive)
                    flag_mismatch("pump_drive", int'(o_pump_drive), int'(want.pump_drive));
                if (o_module_done !== want.module_done)
                    flag_mismatch("module_done", int'(o_module_done),
                                  int'(want.module_done));
                if (o_pop_step !== want.pop_step)
                    flag_mismatch("pop_step", int'(o_pop_step), int'(want.pop_step));
                if (o_phase_code !== want.phase_code)
                    flag_mismatch("phase_code", int'(o_phase_code), int'(want.phase_code));
            end
        end
    end

    // Walks through every phase with the reset register values, hitting the
    // boundaries of the weight compares and each fault flag alone.
    task automatic test_directed_phases();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_request(make_request(UNKNOWN_POS, 0, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(3, 0, FLAG_STOP, 0, 0, 0, 0));
        send_request(make_request(3, 0, FLAG_ERROR, 0, 0, 0, 0));
        send_request(make_request(3, 0, FLAG_CRITICAL, 0, 0, 0, 0));
        send_request(make_request(3, 0, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(UNKNOWN_POS, 0, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(15, 0, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(7, 65535, FLAG_NONE, 0, 9, 500, 1));
        send_request(make_request(7, 65535, FLAG_NONE, 1, 9, 0, 1));
        send_request(make_request(7, 200, FLAG_NONE, 1, 9, 1, 1));
        send_request(make_request(7, 201, FLAG_NONE, 1, 15, 65535, 1));
        send_request(make_request(0, 0, FLAG_NONE, 1, 2, 3, 0));
        send_request(make_request(UNKNOWN_POS, 0, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(15, 0, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(15, 65534, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(15, 65535, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(15, 200, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(15, 199, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(5, 65535, FLAG_NONE, 1, 0, 65535, 0));
        send_request(make_request(UNKNOWN_POS, 65535, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(3, 65535, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(0, 65535, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(0, 65535, FLAG_NONE, 0, 0, 0, 0));
        send_request(make_request(0, 65535, FLAG_ALL, 0, 0, 0, 0));
        send_request(make_request(0, 0, FLAG_NONE, 0, 0, 0, 0));
    endtask

    task automatic test_dosing_cycles();
        gaps_on   = 1'b1;
        stall_on  = 1'b1;
        stall_max = 6;
        repeat (600) send_request(shaped_request());
        // A stretch at full rate on both sides.
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (200) send_request(shaped_request());
    endtask

    task automatic test_register_settings();
        logic [15:0] empties[5];
        logic [15:0] speeds[5];
        logic [15:0] pumps[5];
        empties = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 3000)), 16'($urandom()), 16'd200};
        speeds  = '{16'd0, 16'd127, 16'($urandom_range(1, 126)), 16'($urandom_range(0, 127)),
                    16'd25};
        pumps   = '{16'd0, 16'd255, 16'($urandom_range(1, 254)), 16'($urandom_range(0, 255)),
                    16'd40};
        gaps_on   = 1'b1;
        stall_on  = 1'b1;
        stall_max = 4;
        for (int s = 0; s < 5; s++) begin
            wait_idle();
            write_register(CFG_EMPTY_GLASS, empties[s]);
            write_register(CFG_SEL_SPEED, speeds[s]);
            write_register(CFG_PUMP_LEVEL, pumps[s]);
            repeat (90) send_request(shaped_request());
        end
    endtask

    task automatic test_noise_items();
        gaps_on   = 1'b1;
        stall_on  = 1'b1;
        stall_max = 12;
        repeat (150) send_request(noise_request());
    endtask

    initial begin : run_tests
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_selector_index = '0;
        i_glass_weight   = '0;
        i_stop_mode      = 1'b0;
        i_error_flag     = 1'b0;
        i_critical_flag  = 1'b0;
        i_step_present   = 1'b0;
        i_step_bottle    = '0;
        i_step_amount    = '0;
        i_step_final     = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        errors           = 0;
        burst_left       = 0;
        gaps_on          = 1'b0;
        stall_on         = 1'b0;
        stall_max        = 1;
        reset_sequencer();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_phases();
        test_dosing_cycles();
        test_register_settings();
        test_noise_items();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (awaited_commands.size() != 0)
            flag_mismatch("requests left without command", awaited_commands.size(), 0);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/wds_pkg.sv
hw/rtl/wds_cfg.sv
hw/rtl/wds_step.sv
hw/rtl/weighed_dosing_sequencer.sv
verif/weighed_dosing_sequencer_test.sv
